FILE: sv/tchu_pkg.sv
// Shared types and codes for the transmit command handshake unit.
package tchu_pkg;

  typedef enum logic [2:0] {
    PH_IDLE  = 3'd0,
    PH_ACK   = 3'd1,
    PH_LOW   = 3'd2,
    PH_READY = 3'd3,
    PH_END   = 3'd4
  } phase_e;

  typedef enum logic [1:0] {
    OP_START = 2'd0,
    OP_TICK  = 2'd1,
    OP_END   = 2'd2,
    OP_BAD   = 2'd3
  } op_e;

  typedef enum logic [2:0] {
    ACT_STATUS = 3'd0,
    ACT_BYTE   = 3'd1,
    ACT_WORD   = 3'd2,
    ACT_INT    = 3'd3,
    ACT_DONE   = 3'd4
  } action_e;

  typedef enum logic [2:0] {
    CODE_OK      = 3'd0,
    CODE_TIMEOUT = 3'd1,
    CODE_NAK     = 3'd2,
    CODE_ENDFAIL = 3'd3,
    CODE_BUSY    = 3'd4
  } code_e;

  localparam logic [1:0] CfgBus16   = 2'd0;
  localparam logic [1:0] CfgAckLim  = 2'd1;
  localparam logic [1:0] CfgLowLim  = 2'd2;
  localparam logic [1:0] CfgEndLim  = 2'd3;

  localparam logic [7:0] StTxReq     = 8'h01;
  localparam logic [7:0] StAccepted  = 8'h02;
  localparam logic [7:0] StEndOk     = 8'h03;
  localparam logic [7:0] StTimeout   = 8'h04;
  localparam logic [7:0] StNak       = 8'h05;
  localparam logic [7:0] StLowReq    = 8'h06;
  localparam logic [7:0] StLowAck    = 8'h07;
  localparam logic [7:0] StNakAck    = 8'h08;
  localparam logic [7:0] StClear     = 8'h00;

  localparam logic [15:0] AckLimReset = 16'd600;
  localparam logic [15:0] LowLimReset = 16'd6800;
  localparam logic [15:0] EndLimReset = 16'd600;

  typedef struct packed {
    action_e     action;
    logic [15:0] value;
    code_e       code;
  } result_t;

  typedef struct packed {
    logic        bus16;
    logic [15:0] ack_lim;
    logic [15:0] low_lim;
    logic [15:0] end_lim;
  } cfg_t;

  typedef struct packed {
    phase_e      phase;
    logic [15:0] poll_count;
    logic [7:0]  held_high;
  } state_t;

endpackage

FILE: sv/tchu_step.sv
// Next-state and result generation for one request.
module tchu_step (
  input  tchu_pkg::op_e        op_i,
  input  logic [15:0]          len_i,
  input  logic [7:0]           status_i,
  input  tchu_pkg::cfg_t       cfg_i,
  input  tchu_pkg::state_t     state_i,
  output tchu_pkg::state_t     state_o,
  output logic [1:0]           num_o,
  output tchu_pkg::result_t [2:0] res_o
);
  import tchu_pkg::*;

  logic [16:0] poll_next;
  logic        ack_out, low_out, end_out;

  assign poll_next = {1'b0, state_i.poll_count} + 17'd1;
  assign ack_out   = poll_next >= {1'b0, cfg_i.ack_lim};
  assign low_out   = poll_next >= {1'b0, cfg_i.low_lim};
  assign end_out   = poll_next >= {1'b0, cfg_i.end_lim};

  function automatic result_t mk(action_e a, logic [15:0] v, code_e c);
    result_t r;
    r.action = a;
    r.value  = v;
    r.code   = c;
    return r;
  endfunction

  always_comb begin
    state_o = state_i;
    num_o   = 2'd0;
    res_o[0] = mk(ACT_DONE, 16'd0, CODE_BUSY);
    res_o[1] = mk(ACT_DONE, 16'd0, CODE_OK);
    res_o[2] = mk(ACT_DONE, 16'd0, CODE_OK);
    if (op_i == OP_START && state_i.phase == PH_IDLE) begin
      state_o.poll_count = 16'd0;
      state_o.held_high  = len_i[15:8];
      num_o = 2'd3;
      res_o[2] = mk(ACT_INT, 16'd0, CODE_OK);
      if (cfg_i.bus16) begin
        res_o[0] = mk(ACT_STATUS, {8'd0, StTxReq}, CODE_OK);
        res_o[1] = mk(ACT_WORD, len_i, CODE_OK);
        state_o.phase = PH_ACK;
      end else begin
        res_o[0] = mk(ACT_STATUS, {8'd0, StLowReq}, CODE_OK);
        res_o[1] = mk(ACT_BYTE, {8'd0, len_i[7:0]}, CODE_OK);
        state_o.phase = PH_LOW;
      end
    end else if (op_i == OP_END && state_i.phase == PH_READY) begin
      state_o.poll_count = 16'd0;
      state_o.phase      = PH_END;
    end else if (op_i == OP_TICK && state_i.phase == PH_ACK) begin
      if (status_i == StAccepted) begin
        num_o = 2'd1;
        res_o[0] = mk(ACT_DONE, 16'd0, CODE_OK);
        state_o.poll_count = 16'd0;
        state_o.phase      = PH_READY;
      end else if (status_i == StNak) begin
        num_o = 2'd3;
        res_o[0] = mk(ACT_STATUS, {8'd0, StNakAck}, CODE_OK);
        res_o[1] = mk(ACT_INT, 16'd0, CODE_OK);
        res_o[2] = mk(ACT_DONE, 16'd0, CODE_NAK);
        state_o.poll_count = 16'd0;
        state_o.phase      = PH_IDLE;
      end else if (ack_out) begin
        num_o = 2'd2;
        res_o[0] = mk(ACT_STATUS, {8'd0, StTimeout}, CODE_OK);
        res_o[1] = mk(ACT_DONE, 16'd0, CODE_TIMEOUT);
        state_o.poll_count = 16'd0;
        state_o.phase      = PH_IDLE;
      end else begin
        state_o.poll_count = poll_next[15:0];
      end
    end else if (op_i == OP_TICK && state_i.phase == PH_LOW) begin
      if (status_i == StLowAck) begin
        num_o = 2'd2;
        res_o[0] = mk(ACT_BYTE, {8'd0, state_i.held_high}, CODE_OK);
        res_o[1] = mk(ACT_STATUS, {8'd0, StTxReq}, CODE_OK);
        state_o.poll_count = 16'd0;
        state_o.phase      = PH_ACK;
      end else if (low_out) begin
        num_o = 2'd2;
        res_o[0] = mk(ACT_STATUS, {8'd0, StTimeout}, CODE_OK);
        res_o[1] = mk(ACT_DONE, 16'd0, CODE_TIMEOUT);
        state_o.poll_count = 16'd0;
        state_o.phase      = PH_IDLE;
      end else begin
        state_o.poll_count = poll_next[15:0];
      end
    end else if (op_i == OP_TICK && state_i.phase == PH_END) begin
      if (status_i == StEndOk) begin
        num_o = 2'd2;
        res_o[0] = mk(ACT_STATUS, {8'd0, StClear}, CODE_OK);
        res_o[1] = mk(ACT_DONE, 16'd0, CODE_OK);
        state_o.poll_count = 16'd0;
        state_o.phase      = PH_IDLE;
      end else if (end_out) begin
        num_o = 2'd1;
        res_o[0] = mk(ACT_DONE, 16'd0, CODE_ENDFAIL);
        state_o.poll_count = 16'd0;
        state_o.phase      = PH_IDLE;
      end else begin
        state_o.poll_count = poll_next[15:0];
      end
    end else begin
      // wrong phase or unused op: report busy, keep state
      num_o = 2'd1;
    end
  end

endmodule

FILE: sv/tchu_out_buf.sv
// Result register holding the up to three results of one request.
module tchu_out_buf (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    load_i,
  input  logic [1:0]              num_i,
  input  tchu_pkg::result_t [2:0] res_i,
  output logic                    space_o,
  output logic [1:0]              count_o,
  output logic                    valid_o,
  input  logic                    ready_i,
  output tchu_pkg::result_t       head_o,
  output logic                    last_o
);
  import tchu_pkg::*;

  result_t [2:0] buf_q, buf_d;
  logic [1:0]    cnt_q, cnt_d;
  logic          pop;

  assign pop     = valid_o && ready_i;
  assign valid_o = cnt_q != 2'd0;
  assign last_o  = cnt_q == 2'd1;
  assign head_o  = buf_q[0];
  assign count_o = cnt_q;
  // take a new request when empty or once the last pending result leaves this cycle
  assign space_o = (cnt_q == 2'd0) || (cnt_q == 2'd1 && ready_i);

  always_comb begin
    buf_d = buf_q;
    cnt_d = cnt_q;
    if (load_i) begin
      buf_d = res_i;
      cnt_d = num_i;
    end else if (pop) begin
      buf_d[0] = buf_q[1];
      buf_d[1] = buf_q[2];
      cnt_d    = cnt_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= 2'd0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    buf_q <= buf_d;
  end

endmodule

FILE: sv/tx_command_handshake_unit.sv
// Top level of the transmit command handshake unit.
//
// Requests arrive on the s_ channel: tuser carries the op (start, tick,
// end), tdata the message length and the transmit status seen this tick.
// Each request yields zero to three results on the m_ channel: tuser is
// the action, tdata the written value and the completion code, tlast
// marks the final result of the request.
// The first result of a request is valid in the cycle after it is
// accepted. Results leave one per cycle, while the receiver is ready,
// from a three-entry result register; the next request is taken in
// the cycle its last result leaves.
// Requests with no result (end, unmatched tick) are taken every cycle.
// A stalled receiver holds the current result and blocks new requests
// once the result register is not about to empty.
// Reset puts the phase in idle, clears the poll counter and loads the
// register defaults (16-bit bus, limits 600 / 6800 / 600).
// Configuration writes through cfg_we_i take effect on the next request.
module tx_command_handshake_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [15:0] cfg_data_i,
  input  logic        s_tvalid_i,
  output logic        s_tready_o,
  input  logic [23:0] s_tdata_i,   // [15:0] msg_length, [23:16] observed_status
  input  logic [1:0]  s_tuser_i,   // [1:0] op
  output logic        m_tvalid_o,
  input  logic        m_tready_i,
  output logic [23:0] m_tdata_o,   // [15:0] value, [18:16] done_code, [23:19] zero
  output logic [2:0]  m_tuser_o,   // [2:0] action
  output logic        m_tlast_o
);
  import tchu_pkg::*;

  cfg_t              cfg_q;
  state_t            state_q, state_d;
  logic [1:0]        num;
  result_t [2:0]     res;
  result_t           head;
  logic              accept;
  logic [1:0]        pend;

  tchu_step u_step (
    .op_i     (op_e'(s_tuser_i)),
    .len_i    (s_tdata_i[15:0]),
    .status_i (s_tdata_i[23:16]),
    .cfg_i    (cfg_q),
    .state_i  (state_q),
    .state_o  (state_d),
    .num_o    (num),
    .res_o    (res)
  );

  tchu_out_buf u_buf (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .load_i  (accept),
    .num_i   (num),
    .res_i   (res),
    .space_o (s_tready_o),
    .count_o (pend),
    .valid_o (m_tvalid_o),
    .ready_i (m_tready_i),
    .head_o  (head),
    .last_o  (m_tlast_o)
  );

  assign accept    = s_tvalid_i && s_tready_o;
  assign m_tdata_o = {5'd0, head.code, head.value};
  assign m_tuser_o = head.action;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.bus16   <= 1'b1;
      cfg_q.ack_lim <= AckLimReset;
      cfg_q.low_lim <= LowLimReset;
      cfg_q.end_lim <= EndLimReset;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CfgBus16:  cfg_q.bus16   <= cfg_data_i[0];
        CfgAckLim: cfg_q.ack_lim <= cfg_data_i;
        CfgLowLim: cfg_q.low_lim <= cfg_data_i;
        CfgEndLim: cfg_q.end_lim <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q.phase      <= PH_IDLE;
      state_q.poll_count <= 16'd0;
      state_q.held_high  <= 8'd0;
    end else if (accept) begin
      state_q <= state_d;
    end
  end

  a_load_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |-> pend <= 2'd1)
    else $error("request taken with more than one result pending");

  a_idle_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q.phase == PH_IDLE || state_q.phase == PH_READY) |-> state_q.poll_count == 16'd0)
    else $error("poll counter not cleared outside a wait");

  a_busy_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && s_tuser_i == OP_BAD) |=>
      (m_tvalid_o && m_tlast_o && m_tuser_o == ACT_DONE && m_tdata_o[18:16] == CODE_BUSY))
    else $error("unused op did not report busy");

  a_last_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_tvalid_o && m_tready_i && !m_tlast_o) |=> m_tvalid_o)
    else $error("result burst ended without last");

endmodule

FILE: test/tb_top.sv
// Self-checking testbench for the transmit command handshake unit.
`timescale 1ns / 1ps

module tb_top;
  import tchu_pkg::*;

  typedef struct packed {
    op_e         op;
    logic [15:0] len;
    logic [7:0]  status;
  } tx_request_t;

  typedef struct packed {
    action_e     action;
    logic [15:0] value;
    code_e       code;
    logic        last;
  } tx_result_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_we_i = 1'b0;
  logic [1:0]  cfg_idx_i = CfgBus16;
  logic [15:0] cfg_data_i = 16'h0000;
  logic        s_tvalid_i = 1'b0;
  logic        s_tready_o;
  logic [23:0] s_tdata_i = 24'h000000;  // [15:0] msg_length, [23:16] observed_status
  logic [1:0]  s_tuser_i = OP_START;    // [1:0] op
  logic        m_tvalid_o;
  logic        m_tready_i = 1'b1;
  logic [23:0] m_tdata_o;               // [15:0] value, [18:16] done_code, [23:19] zero
  logic [2:0]  m_tuser_o;               // [2:0] action
  logic        m_tlast_o;

  tx_command_handshake_unit dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .s_tvalid_i (s_tvalid_i),
    .s_tready_o (s_tready_o),
    .s_tdata_i  (s_tdata_i),
    .s_tuser_i  (s_tuser_i),
    .m_tvalid_o (m_tvalid_o),
    .m_tready_i (m_tready_i),
    .m_tdata_o  (m_tdata_o),
    .m_tuser_o  (m_tuser_o),
    .m_tlast_o  (m_tlast_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  tx_request_t pending_requests[$];
  tx_result_t  predicted_results[$];

  // Handshake model state and register copy
  cfg_t        cfg_m;
  phase_e      phase_m;
  logic [15:0] poll_cnt_m;
  logic [7:0]  high_byte_m;
  tx_result_t  step_buf[3];
  int unsigned step_n;

  bit          calm;
  int unsigned fail_cnt;
  int unsigned queued_cnt;
  int unsigned requests_taken;
  int unsigned results_checked;
  int unsigned settings_cnt;
  int unsigned code_seen[5];

  function automatic void note_result(action_e a, logic [15:0] v, code_e c);
    step_buf[step_n] = '{a, v, c, 1'b0};
    step_n++;
  endfunction

  // Count one unmatched observation; true when the limit is used up.
  function automatic bit limit_hit(logic [15:0] lim);
    logic [16:0] bumped;
    bumped = {1'b0, poll_cnt_m} + 17'd1;
    if (bumped >= {1'b0, lim}) begin
      poll_cnt_m = 16'h0000;
      return 1'b1;
    end
    poll_cnt_m = bumped[15:0];
    return 1'b0;
  endfunction

  function automatic void predict_handshake(op_e op, logic [15:0] len, logic [7:0] st);
    step_n = 0;
    if (op == OP_START && phase_m == PH_IDLE) begin
      poll_cnt_m = 16'h0000;
      high_byte_m = len[15:8];
      if (cfg_m.bus16) begin
        note_result(ACT_STATUS, {8'h00, StTxReq}, CODE_OK);
        note_result(ACT_WORD, len, CODE_OK);
        note_result(ACT_INT, 16'h0000, CODE_OK);
        phase_m = PH_ACK;
      end else begin
        note_result(ACT_STATUS, {8'h00, StLowReq}, CODE_OK);
        note_result(ACT_BYTE, {8'h00, len[7:0]}, CODE_OK);
        note_result(ACT_INT, 16'h0000, CODE_OK);
        phase_m = PH_LOW;
      end
    end else if (op == OP_END && phase_m == PH_READY) begin
      poll_cnt_m = 16'h0000;
      phase_m = PH_END;
    end else if (op == OP_TICK && phase_m == PH_ACK) begin
      if (st == StAccepted) begin
        note_result(ACT_DONE, 16'h0000, CODE_OK);
        poll_cnt_m = 16'h0000;
        phase_m = PH_READY;
      end else if (st == StNak) begin
        note_result(ACT_STATUS, {8'h00, StNakAck}, CODE_OK);
        note_result(ACT_INT, 16'h0000, CODE_OK);
        note_result(ACT_DONE, 16'h0000, CODE_NAK);
        poll_cnt_m = 16'h0000;
        phase_m = PH_IDLE;
      end else if (limit_hit(cfg_m.ack_lim)) begin
        note_result(ACT_STATUS, {8'h00, StTimeout}, CODE_OK);
        note_result(ACT_DONE, 16'h0000, CODE_TIMEOUT);
        phase_m = PH_IDLE;
      end
    end else if (op == OP_TICK && phase_m == PH_LOW) begin
      if (st == StLowAck) begin
        note_result(ACT_BYTE, {8'h00, high_byte_m}, CODE_OK);
        note_result(ACT_STATUS, {8'h00, StTxReq}, CODE_OK);
        poll_cnt_m = 16'h0000;
        phase_m = PH_ACK;
      end else if (limit_hit(cfg_m.low_lim)) begin
        note_result(ACT_STATUS, {8'h00, StTimeout}, CODE_OK);
        note_result(ACT_DONE, 16'h0000, CODE_TIMEOUT);
        phase_m = PH_IDLE;
      end
    end else if (op == OP_TICK && phase_m == PH_END) begin
      if (st == StEndOk) begin
        note_result(ACT_STATUS, {8'h00, StClear}, CODE_OK);
        note_result(ACT_DONE, 16'h0000, CODE_OK);
        poll_cnt_m = 16'h0000;
        phase_m = PH_IDLE;
      end else if (limit_hit(cfg_m.end_lim)) begin
        note_result(ACT_DONE, 16'h0000, CODE_ENDFAIL);
        phase_m = PH_IDLE;
      end
    end else begin
      note_result(ACT_DONE, 16'h0000, CODE_BUSY);
    end
    if (step_n != 0) step_buf[step_n - 1].last = 1'b1;
    for (int i = 0; i < step_n; i++) predicted_results.push_back(step_buf[i]);
  endfunction

  // Mostly no gap, some short ones, a few long ones
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (calm || r < 75) return 0;
    if (r < 96) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Driver: one request on the slave side, replaced once taken
  int unsigned gap_left;
  always @(posedge clk_i) begin
    tx_request_t req;
    if (s_tvalid_i && s_tready_o) begin
      predict_handshake(op_e'(s_tuser_i), s_tdata_i[15:0], s_tdata_i[23:16]);
      requests_taken++;
    end
    if (!s_tvalid_i || s_tready_o) begin
      if (gap_left != 0) begin
        gap_left--;
        s_tvalid_i <= 1'b0;
      end else if (pending_requests.size() != 0) begin
        req = pending_requests.pop_front();
        s_tuser_i <= req.op;
        s_tdata_i <= {req.status, req.len};
        s_tvalid_i <= 1'b1;
        gap_left = pick_gap();
      end else begin
        s_tvalid_i <= 1'b0;
      end
    end
  end

  function automatic void check_field(string name, int unsigned want, int unsigned got);
    if (want != got) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      fail_cnt++;
    end
  endfunction

  // Monitor: compare each result with the oldest prediction
  int unsigned stall_left;
  always @(posedge clk_i) begin
    tx_result_t want;
    if (rst_ni) begin
      if (m_tvalid_o && m_tready_i) begin
        if (predicted_results.size() == 0) begin
          $error("unexpected result: action %0h, tdata %0h", m_tuser_o, m_tdata_o);
          fail_cnt++;
        end else begin
          want = predicted_results.pop_front();
          check_field("action", want.action, m_tuser_o);
          check_field("value", want.value, m_tdata_o[15:0]);
          check_field("done_code", want.code, m_tdata_o[18:16]);
          check_field("tdata padding", 0, m_tdata_o[23:19]);
          check_field("last", want.last, m_tlast_o);
          if (want.action == ACT_DONE) code_seen[want.code]++;
          results_checked++;
        end
      end
      if (stall_left != 0) begin
        stall_left--;
        m_tready_i <= 1'b0;
      end else begin
        m_tready_i <= 1'b1;
        stall_left = pick_gap();
      end
    end
  end

  function automatic void queue_request(op_e op, logic [15:0] len, logic [7:0] st);
    pending_requests.push_back('{op, len, st});
    queued_cnt++;
  endfunction

  function automatic logic [7:0] miss_status(logic [7:0] a, logic [7:0] b);
    logic [7:0] s;
    s = $urandom_range(0, 1) ? 8'($urandom_range(0, 8)) : 8'($urandom);
    while (s == a || s == b) s = 8'($urandom);
    return s;
  endfunction

  // Queue unmatched ticks; true if they run the poll limit out.
  function automatic bit queue_misses(logic [15:0] lim, logic [7:0] a, logic [7:0] b);
    int unsigned eff;
    int unsigned n;
    eff = (lim == 0) ? 1 : lim;
    n = $urandom_range(0, (eff <= 4) ? eff : 3);
    for (int i = 0; i < n; i++) queue_request(OP_TICK, 16'($urandom), miss_status(a, b));
    return n >= eff;
  endfunction

  function automatic void queue_transfer();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 12) begin
      queue_request(op_e'($urandom_range(0, 3)), 16'($urandom), 8'($urandom));
      return;
    end
    queue_request(OP_START, 16'($urandom), 8'($urandom));
    if (!cfg_m.bus16) begin
      if (queue_misses(cfg_m.low_lim, StLowAck, StLowAck)) return;
      queue_request(OP_TICK, 16'($urandom), StLowAck);
    end
    if (queue_misses(cfg_m.ack_lim, StAccepted, StNak)) return;
    if ($urandom_range(0, 99) < 25) begin
      queue_request(OP_TICK, 16'($urandom), StNak);
      return;
    end
    queue_request(OP_TICK, 16'($urandom), StAccepted);
    // occasional wrong-phase request while the end is awaited
    if ($urandom_range(0, 9) == 0)
      queue_request($urandom_range(0, 1) ? OP_START : OP_TICK, 16'($urandom), 8'($urandom));
    queue_request(OP_END, 16'($urandom), 8'($urandom));
    if (queue_misses(cfg_m.end_lim, StEndOk, StEndOk)) return;
    queue_request(OP_TICK, 16'($urandom), StEndOk);
  endfunction

  task automatic write_reg(logic [1:0] idx, logic [15:0] data);
    @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= data;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      CfgBus16:  cfg_m.bus16 = data[0];
      CfgAckLim: cfg_m.ack_lim = data;
      CfgLowLim: cfg_m.low_lim = data;
      default:   cfg_m.end_lim = data;
    endcase
  endtask

  task automatic write_all(logic bus16, logic [15:0] ack, logic [15:0] low, logic [15:0] fin);
    write_reg(CfgBus16, {15'd0, bus16});
    write_reg(CfgAckLim, ack);
    write_reg(CfgLowLim, low);
    write_reg(CfgEndLim, fin);
    settings_cnt++;
  endtask

  // Wait until every request is taken and answered, then let the block settle
  task automatic wait_drain();
    while (requests_taken != queued_cnt || predicted_results.size() != 0)
      @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic run_random(int unsigned n);
    int unsigned first;
    first = queued_cnt;
    while (queued_cnt - first < n) queue_transfer();
    wait_drain();
  endtask

  initial begin
    cfg_m = '{1'b1, AckLimReset, LowLimReset, EndLimReset};
    phase_m = PH_IDLE;
    poll_cnt_m = 16'h0000;
    high_byte_m = 8'h00;
    settings_cnt = 1;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Wrong-phase requests, 16-bit handshake, refusal, accept and end
    queue_request(OP_TICK, 16'hffff, StAccepted);
    queue_request(OP_END, 16'h0000, 8'h00);
    queue_request(OP_BAD, 16'hffff, 8'hff);
    queue_request(OP_START, 16'hffff, 8'hff);
    queue_request(OP_START, 16'h0000, 8'h00);
    queue_request(OP_END, 16'h0000, 8'h00);
    queue_request(OP_TICK, 16'h0000, 8'hff);
    queue_request(OP_TICK, 16'h0000, StNak);
    queue_request(OP_START, 16'h0000, 8'h00);
    queue_request(OP_TICK, 16'hffff, 8'h00);
    queue_request(OP_TICK, 16'h0000, StAccepted);
    queue_request(OP_TICK, 16'h0000, StAccepted);
    queue_request(OP_END, 16'hffff, 8'hff);
    queue_request(OP_END, 16'h0000, 8'h00);
    queue_request(OP_TICK, 16'h0000, StLowAck);
    queue_request(OP_TICK, 16'h0000, StEndOk);
    wait_drain();

    // 8-bit path with tight limits: low byte ack, timeouts in both waits
    write_all(1'b0, 16'd1, 16'd2, 16'd1);
    queue_request(OP_START, 16'ha55a, 8'h00);
    queue_request(OP_TICK, 16'h0000, 8'h00);
    queue_request(OP_TICK, 16'h0000, StLowAck);
    queue_request(OP_TICK, 16'h0000, StLowReq);
    queue_request(OP_START, 16'h1234, 8'h00);
    queue_request(OP_TICK, 16'h0000, StTxReq);
    queue_request(OP_TICK, 16'h0000, StAccepted);
    queue_request(OP_START, 16'h00ff, 8'h00);
    wait_drain();

    // Switch to 16-bit mid-handshake: the 8-bit sequence must carry on
    write_all(1'b1, 16'd2, 16'd2, 16'd1);
    queue_request(OP_TICK, 16'h0000, StLowAck);
    queue_request(OP_TICK, 16'h0000, StAccepted);
    queue_request(OP_END, 16'h0000, 8'h00);
    queue_request(OP_TICK, 16'h0000, 8'h11);
    wait_drain();

    calm = 1'b1;
    write_all(1'b1, 16'd3, 16'd3, 16'd2);
    run_random(18);
    calm = 1'b0;
    write_all(1'b0, 16'd1, 16'd1, 16'd1);
    run_random(18);
    write_all(1'b0, 16'hffff, 16'hffff, 16'hffff);
    run_random(18);
    write_all(1'($urandom), 16'd0, 16'd0, 16'd0);
    run_random(18);
    write_all(1'($urandom), 16'($urandom_range(1, 8)), 16'($urandom_range(1, 8)),
              16'($urandom_range(1, 8)));
    run_random(18);

    repeat (10) @(posedge clk_i);
    $display("Ran %0d requests over %0d register settings, %0d results compared",
             requests_taken, settings_cnt, results_checked);
    $display("Completions seen: ok %0d, timeout %0d, refused %0d, end failed %0d, busy %0d",
             code_seen[CODE_OK], code_seen[CODE_TIMEOUT], code_seen[CODE_NAK],
             code_seen[CODE_ENDFAIL], code_seen[CODE_BUSY]);
    if (fail_cnt == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $error("run did not finish in time");
    $display("*** FAILED ***");
    $finish;
  end

endmodule
